FILE: rtl/mcfe_pkg.sv
// Shared types, constants and face tables for the mesh contact face extractor.
`timescale 1ns / 1ps
package mcfe_pkg;

   localparam int NODE_W         = 20;
   localparam int ELEM_W         = 32;
   localparam int SURF_W         = 16;
   localparam int NUM_NODES      = 8;
   localparam int NUM_FACES      = 6;
   localparam int NUM_TET_FACES  = 4;
   localparam int HEX_THRESHOLD  = 4;
   localparam int TET_THRESHOLD  = 3;
   localparam int NODE_COUNT_DEF = 1048576;

   // flag store row geometry
   localparam int ROW_BITS   = 16;
   localparam int ROW_SEL_W  = 4;
   localparam int ROW_ADDR_W = 20;

   localparam logic KIND_FLAG = 1'b0;
   localparam logic KIND_ELEM = 1'b1;

   // corner order of each face, node numbers from 0
   localparam logic [0:NUM_FACES-1][0:3][2:0] HEX_FACE = '{
      '{3'd0, 3'd1, 3'd2, 3'd3}, '{3'd7, 3'd6, 3'd5, 3'd4}, '{3'd0, 3'd3, 3'd7, 3'd4},
      '{3'd1, 3'd0, 3'd4, 3'd5}, '{3'd2, 3'd1, 3'd5, 3'd6}, '{3'd3, 3'd2, 3'd6, 3'd7}
   };
   localparam logic [0:NUM_TET_FACES-1][0:2][2:0] TET_FACE = '{
      '{3'd0, 3'd1, 3'd2}, '{3'd0, 3'd2, 3'd3}, '{3'd0, 3'd3, 3'd1}, '{3'd2, 3'd1, 3'd3}
   };

   typedef struct packed {
      logic              kind;
      logic [ELEM_W-1:0] element_id;
      logic              hex_element;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic [NODE_W-1:0] node_c;
      logic [NODE_W-1:0] node_d;
      logic [NODE_W-1:0] node_e;
      logic [NODE_W-1:0] node_f;
      logic [NODE_W-1:0] node_g;
      logic [NODE_W-1:0] node_h;
      logic              flag_value;
   } req_type;

   typedef struct packed {
      logic [ELEM_W-1:0] face_element;
      logic [NODE_W-1:0] corner_1;
      logic [NODE_W-1:0] corner_2;
      logic [NODE_W-1:0] corner_3;
      logic [NODE_W-1:0] corner_4;
      logic              quad_face;
      logic [SURF_W-1:0] face_surface;
      logic              face_valid;
      logic              accepted;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic                  rd_en;
      logic                  wr_en;
      logic [ROW_ADDR_W-1:0] row;
      logic [ROW_BITS-1:0]   wdata;
   } store_req_type;

   typedef struct packed {
      logic                   enable;
      logic                   quad;
      logic [3:0]             flags;
      logic [3:0][NODE_W-1:0] nodes;
   } face_in_type;

   typedef struct packed {
      logic                   match;
      logic                   quad;
      logic [3:0][NODE_W-1:0] corners;
   } face_type;

   typedef struct packed {
      logic              start;
      logic              accepted;
      logic [ELEM_W-1:0] element_id;
   } merge_load_type;

   function automatic logic [ROW_ADDR_W-1:0] row_of(input logic [NODE_W-1:0] node);
      return ROW_ADDR_W'(node >> ROW_SEL_W);
   endfunction

endpackage

FILE: rtl/mesh_contact_face_extractor.sv
// Top level: flag store sequencer, six face lanes and the merge stage.
// Element: accept, then one flag lookup per node (8 hex, 4 tet), serialized by the single
// store port; a drain step follows, then the hand-off to the merge stage once it is idle.
// Flag write: read-modify-write of one 16-flag row. Results: one beat a cycle while rsp_ready is high.
// Reset (synchronous, high) clears control and starts a clearing pass over
// ceil(NODE_COUNT/16) flag rows, during which req_ready is low; csr writes still land.
`timescale 1ns / 1ps
module mesh_contact_face_extractor
   import mcfe_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [SURF_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      IDLE,
      FLAG_RD,
      FLAG_WR,
      LOOK,
      DRAIN,
      FINISH
   } state_type;

   state_type                       state_ff, state_in;
   req_type                         item_ff;
   logic [2:0]                      idx_ff, idx_in;
   logic                            cap_en_ff;
   logic [2:0]                      cap_idx_ff;
   logic [NUM_NODES-1:0]            flags_ff;
   logic [SURF_W-1:0]               surface_ff;
   logic [NUM_NODES-1:0][NODE_W-1:0] node_vec;
   logic [NODE_W-1:0]               cap_node;
   logic [ROW_BITS-1:0]             store_rd;
   logic [ROW_BITS-1:0]             wr_row;
   logic                            clearing;
   logic                            accept;
   logic                            merge_idle;
   logic [2:0]                      last_idx;
   logic [3:0]                      flag_cnt;
   logic [3:0]                      threshold;
   store_req_type                   store_req;
   merge_load_type                  merge_load;
   face_type                        lane_out [NUM_FACES];

   function automatic logic node_ok(input logic [NODE_W-1:0] node);
      return {{(32 - NODE_W){1'b0}}, node} < 32'(NODE_COUNT);
   endfunction

   assign req_ready = (state_ff == IDLE) & ~clearing;
   assign accept    = req_valid & req_ready;

   assign node_vec = {item_ff.node_h, item_ff.node_g, item_ff.node_f, item_ff.node_e,
                      item_ff.node_d, item_ff.node_c, item_ff.node_b, item_ff.node_a};
   assign last_idx  = item_ff.hex_element ? 3'(NUM_NODES - 1) : 3'(NUM_TET_FACES - 1);
   assign flag_cnt  = 4'($countones(flags_ff));
   assign threshold = item_ff.hex_element ? 4'(HEX_THRESHOLD) : 4'(TET_THRESHOLD);
   assign cap_node  = node_vec[cap_idx_ff];

   always_comb begin
      wr_row                          = store_rd;
      wr_row[item_ff.node_a[ROW_SEL_W-1:0]] = item_ff.flag_value;
   end

   always_comb begin
      state_in              = state_ff;
      idx_in                = idx_ff;
      store_req             = '0;
      merge_load.start      = 1'b0;
      merge_load.accepted   = flag_cnt >= threshold;
      merge_load.element_id = item_ff.element_id;
      case (state_ff)
         IDLE: begin
            idx_in = '0;
            if (accept) begin
               if (req_data.kind == KIND_ELEM) begin
                  state_in = LOOK;
               end else if (node_ok(req_data.node_a)) begin
                  state_in = FLAG_RD;
               end
            end
         end
         FLAG_RD: begin
            store_req.rd_en = 1'b1;
            store_req.row   = row_of(item_ff.node_a);
            state_in        = FLAG_WR;
         end
         FLAG_WR: begin
            store_req.wr_en = 1'b1;
            store_req.row   = row_of(item_ff.node_a);
            store_req.wdata = wr_row;
            state_in        = IDLE;
         end
         LOOK: begin
            store_req.rd_en = 1'b1;
            store_req.row   = row_of(node_vec[idx_ff]);
            idx_in          = idx_ff + 1'b1;
            if (idx_ff == last_idx) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            state_in = FINISH;
         end
         FINISH: begin
            if (merge_idle) begin
               merge_load.start = 1'b1;
               state_in         = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         idx_ff     <= '0;
         cap_en_ff  <= 1'b0;
         cap_idx_ff <= '0;
         surface_ff <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         cap_en_ff  <= (state_ff == LOOK);
         cap_idx_ff <= idx_ff;
         if (csr_we) begin
            surface_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff  <= req_data;
         flags_ff <= '0;
      end else if (cap_en_ff) begin
         flags_ff[cap_idx_ff] <= node_ok(cap_node) & store_rd[cap_node[ROW_SEL_W-1:0]];
      end
   end

   mcfe_flag_store #(
      .NODE_COUNT(NODE_COUNT)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .store_req(store_req),
      .rd_data  (store_rd),
      .clearing (clearing)
   );

   for (genvar f = 0; f < NUM_FACES; f++) begin : g_lane
      face_in_type lane_in;
      if (f < NUM_TET_FACES) begin : g_both
         always_comb begin
            lane_in.enable = 1'b1;
            lane_in.quad   = item_ff.hex_element;
            if (item_ff.hex_element) begin
               for (int k = 0; k < 4; k++) begin
                  lane_in.flags[k] = flags_ff[HEX_FACE[f][k]];
                  lane_in.nodes[k] = node_vec[HEX_FACE[f][k]];
               end
            end else begin
               for (int k = 0; k < 3; k++) begin
                  lane_in.flags[k] = flags_ff[TET_FACE[f][k]];
                  lane_in.nodes[k] = node_vec[TET_FACE[f][k]];
               end
               lane_in.flags[3] = 1'b0;
               lane_in.nodes[3] = '0;
            end
         end
      end else begin : g_hex
         always_comb begin
            lane_in.enable = item_ff.hex_element;
            lane_in.quad   = 1'b1;
            for (int k = 0; k < 4; k++) begin
               lane_in.flags[k] = flags_ff[HEX_FACE[f][k]];
               lane_in.nodes[k] = node_vec[HEX_FACE[f][k]];
            end
         end
      end
      mcfe_face_lane u_lane (
         .lane_in (lane_in),
         .lane_out(lane_out[f])
      );
   end

   mcfe_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .load     (merge_load),
      .faces    (lane_out),
      .surface  (surface_ff),
      .idle     (merge_idle),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

FILE: rtl/mcfe_flag_store.sv
// Node contact flag memory, single port, with a clearing sweep after reset.
`timescale 1ns / 1ps
module mcfe_flag_store
   import mcfe_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  store_req_type       store_req,
   output logic [ROW_BITS-1:0] rd_data,
   output logic                clearing
);

   localparam int ROWS = (NODE_COUNT + ROW_BITS - 1) / ROW_BITS;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [ROW_BITS-1:0] mem [ROWS];
   logic [ROW_BITS-1:0] rd_data_ff;
   logic                clr_ff;
   logic                clr_in;
   logic [RW-1:0]       clr_row_ff;
   logic [RW-1:0]       clr_row_in;
   logic                wr_en;
   logic [RW-1:0]       wr_row;
   logic [ROW_BITS-1:0] wr_data;

   always_comb begin
      clr_in     = clr_ff;
      clr_row_in = clr_row_ff;
      if (clr_ff) begin
         clr_row_in = clr_row_ff + 1'b1;
         if (clr_row_ff == RW'(ROWS - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_row_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_row_ff <= clr_row_in;
      end
   end

   assign wr_en   = clr_ff | store_req.wr_en;
   assign wr_row  = clr_ff ? clr_row_ff : store_req.row[RW-1:0];
   assign wr_data = clr_ff ? '0 : store_req.wdata;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.row[RW-1:0]];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_ff;

endmodule

FILE: rtl/mcfe_face_lane.sv
// One face lane: tests that all corners of a face are flagged.
`timescale 1ns / 1ps
module mcfe_face_lane
   import mcfe_pkg::*;
(
   input  face_in_type lane_in,
   output face_type    lane_out
);

   logic all_set;

   assign all_set = lane_in.flags[0] & lane_in.flags[1] & lane_in.flags[2]
                  & (lane_in.flags[3] | ~lane_in.quad);

   always_comb begin
      lane_out.match      = lane_in.enable & all_set;
      lane_out.quad       = lane_in.quad;
      lane_out.corners[0] = lane_in.nodes[0];
      lane_out.corners[1] = lane_in.nodes[1];
      lane_out.corners[2] = lane_in.nodes[2];
      lane_out.corners[3] = lane_in.quad ? lane_in.nodes[3] : '0;
   end

endmodule

FILE: rtl/mcfe_merge.sv
// Merge stage: emits matched faces in face order, or one status beat.
`timescale 1ns / 1ps
module mcfe_merge
   import mcfe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  merge_load_type    load,
   input  face_type          faces [NUM_FACES],
   input  logic [SURF_W-1:0] surface,
   output logic              idle,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   localparam int SEL_W = $clog2(NUM_FACES);

   logic [NUM_FACES-1:0] pend_ff, pend_in;
   logic                 status_ff, status_in;
   logic                 acc_ff;
   logic [ELEM_W-1:0]    elem_ff;
   face_type             face_ff [NUM_FACES];
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [NUM_FACES-1:0] match_mask;
   logic [NUM_FACES-1:0] pend_rest;
   logic [SEL_W-1:0]     sel;
   logic                 busy;
   logic                 emit;

   assign busy = status_ff | (|pend_ff);
   assign emit = busy & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      sel = '0;
      for (int i = NUM_FACES - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel = SEL_W'(i);
         end
      end
      for (int i = 0; i < NUM_FACES; i++) begin
         match_mask[i] = faces[i].match;
      end
   end

   assign pend_rest = pend_ff & ~(NUM_FACES'(1) << sel);

   always_comb begin
      pend_in      = pend_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.face_element = elem_ff;
         rsp_data_in.face_surface = surface;
         rsp_data_in.accepted     = acc_ff;
         if (status_ff) begin
            status_in               = 1'b0;
            rsp_data_in.corner_1    = '0;
            rsp_data_in.corner_2    = '0;
            rsp_data_in.corner_3    = '0;
            rsp_data_in.corner_4    = '0;
            rsp_data_in.quad_face   = 1'b0;
            rsp_data_in.face_valid  = 1'b0;
            rsp_data_in.last        = 1'b1;
         end else begin
            pend_in                 = pend_rest;
            rsp_data_in.corner_1    = face_ff[sel].corners[0];
            rsp_data_in.corner_2    = face_ff[sel].corners[1];
            rsp_data_in.corner_3    = face_ff[sel].corners[2];
            rsp_data_in.corner_4    = face_ff[sel].corners[3];
            rsp_data_in.quad_face   = face_ff[sel].quad;
            rsp_data_in.face_valid  = 1'b1;
            rsp_data_in.last        = ~(|pend_rest);
         end
      end else if (load.start) begin
         pend_in   = load.accepted ? match_mask : '0;
         status_in = ~load.accepted | ~(|match_mask);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         status_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (load.start && !busy) begin
         acc_ff  <= load.accepted;
         elem_ff <= load.element_id;
         for (int i = 0; i < NUM_FACES; i++) begin
            face_ff[i] <= faces[i];
         end
      end
   end

   assign idle      = ~busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      load.start |-> !busy)
      else $error("merge loaded while still emitting");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.face_valid |-> rsp_data.last)
      else $error("status beat not marked last");

   a_face_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.face_valid |-> rsp_data.accepted)
      else $error("face emitted for rejected element");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      !(status_ff && (|pend_ff)))
      else $error("status and faces pending together");

endmodule

FILE: tb/mesh_contact_face_extractor_tb.sv
// Self-checking testbench for the mesh contact face extractor.
`timescale 1ns / 1ps
module mesh_contact_face_extractor_tb;
   import mcfe_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 20;
   localparam int POOL_SIZE     = 24;
   localparam int LONG_HOLD     = 600;
   localparam int PRINT_CAP     = 50;

   typedef logic [NODE_W-1:0] node_id_type;

   localparam logic [0:5][0:3][2:0] HEX_CORNERS = {
      3'd0, 3'd1, 3'd2, 3'd3,  3'd7, 3'd6, 3'd5, 3'd4,  3'd0, 3'd3, 3'd7, 3'd4,
      3'd1, 3'd0, 3'd4, 3'd5,  3'd2, 3'd1, 3'd5, 3'd6,  3'd3, 3'd2, 3'd6, 3'd7
   };
   localparam logic [0:3][0:2][2:0] TET_CORNERS = {
      3'd0, 3'd1, 3'd2,  3'd0, 3'd2, 3'd3,  3'd0, 3'd3, 3'd1,  3'd2, 3'd1, 3'd3
   };

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we    = 1'b0;
   logic [SURF_W-1:0] csr_wdata = '0;

   // predictor state
   bit                contact_flag [NODE_COUNT_DEF];
   logic [SURF_W-1:0] surface_cfg = '0;
   rsp_type           expected_faces [$];
   node_id_type       node_pool [POOL_SIZE];

   bit src_idling    = 1'b1;
   bit rsp_idling    = 1'b1;
   bit long_hold_req = 1'b0;

   int error_count      = 0;
   int cycle_count      = 0;
   int flag_writes      = 0;
   int elements         = 0;
   int hex_elements     = 0;
   int face_beats       = 0;
   int status_beats     = 0;
   int surface_settings = 1;

   mesh_contact_face_extractor DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_faces.size());
         $display("mesh_contact_face_extractor_tb failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   function automatic int corner_of(input bit hex, input int f, input int i);
      if (hex)
         return int'(HEX_CORNERS[f][i]);
      if (i < 3)
         return int'(TET_CORNERS[f][i]);
      return 0;
   endfunction

   function automatic rsp_type face_beat(input logic [ELEM_W-1:0] elem,
                                         input node_id_type c1, c2, c3, c4,
                                         input logic quad, hit, acc, fin);
      rsp_type r;
      r.face_element = elem;
      r.corner_1     = c1;
      r.corner_2     = c2;
      r.corner_3     = c3;
      r.corner_4     = c4;
      r.quad_face    = quad;
      r.face_surface = surface_cfg;
      r.face_valid   = hit;
      r.accepted     = acc;
      r.last         = fin;
      return r;
   endfunction

   // applies one accepted beat to the flag store and queues the faces it yields
   function automatic void predict_faces(input req_type item);
      node_id_type nodes [8];
      bit          flg [8];
      bit          face_hit [6];
      bit          hex;
      int          n, cnt, thr, nf, nc, hits, left, f, i;
      nodes[0] = item.node_a;
      nodes[1] = item.node_b;
      nodes[2] = item.node_c;
      nodes[3] = item.node_d;
      nodes[4] = item.node_e;
      nodes[5] = item.node_f;
      nodes[6] = item.node_g;
      nodes[7] = item.node_h;
      if (item.kind == KIND_FLAG) begin
         if (item.node_a < NODE_COUNT_DEF)
            contact_flag[item.node_a] = item.flag_value;
         flag_writes++;
         return;
      end
      hex = item.hex_element;
      n   = hex ? NUM_NODES : 4;
      thr = hex ? HEX_THRESHOLD : TET_THRESHOLD;
      nf  = hex ? NUM_FACES : NUM_TET_FACES;
      nc  = hex ? 4 : 3;
      cnt = 0;
      for (i = 0; i < 8; i++) begin
         flg[i] = (i < n) ? contact_flag[nodes[i]] : 1'b0;
         cnt += int'(flg[i]);
      end
      hits = 0;
      for (f = 0; f < 6; f++) begin
         face_hit[f] = (cnt >= thr) && (f < nf);
         if (face_hit[f])
            for (i = 0; i < nc; i++)
               face_hit[f] &= flg[corner_of(hex, f, i)];
         hits += int'(face_hit[f]);
      end
      elements++;
      hex_elements += int'(hex);
      face_beats   += hits;
      left = hits;
      for (f = 0; f < nf; f++) begin
         if (face_hit[f]) begin
            left--;
            expected_faces.push_back(face_beat(item.element_id,
               nodes[corner_of(hex, f, 0)], nodes[corner_of(hex, f, 1)],
               nodes[corner_of(hex, f, 2)], hex ? nodes[corner_of(hex, f, 3)] : '0,
               hex, 1'b1, 1'b1, left == 0));
         end
      end
      if (hits == 0) begin
         status_beats++;
         expected_faces.push_back(face_beat(item.element_id, '0, '0, '0, '0,
                                            1'b0, 1'b0, cnt >= thr, 1'b1));
      end
   endfunction

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      if (expected_faces.size() == 0) begin
         report_mismatch("result beat with nothing expected", 64'(got.face_element), '0);
         return;
      end
      want = expected_faces.pop_front();
      if (got.face_element !== want.face_element)
         report_mismatch("face_element", 64'(got.face_element), 64'(want.face_element));
      if (got.corner_1 !== want.corner_1)
         report_mismatch("corner_1", 64'(got.corner_1), 64'(want.corner_1));
      if (got.corner_2 !== want.corner_2)
         report_mismatch("corner_2", 64'(got.corner_2), 64'(want.corner_2));
      if (got.corner_3 !== want.corner_3)
         report_mismatch("corner_3", 64'(got.corner_3), 64'(want.corner_3));
      if (got.corner_4 !== want.corner_4)
         report_mismatch("corner_4", 64'(got.corner_4), 64'(want.corner_4));
      if (got.quad_face !== want.quad_face)
         report_mismatch("quad_face", 64'(got.quad_face), 64'(want.quad_face));
      if (got.face_surface !== want.face_surface)
         report_mismatch("face_surface", 64'(got.face_surface), 64'(want.face_surface));
      if (got.face_valid !== want.face_valid)
         report_mismatch("face_valid", 64'(got.face_valid), 64'(want.face_valid));
      if (got.accepted !== want.accepted)
         report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
      if (got.last !== want.last)
         report_mismatch("last", 64'(got.last), 64'(want.last));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         check_beat(rsp_data);
   end

   // result side: random stall bursts, plus a long hold on request
   initial begin : rsp_side
      int gap;
      gap = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            gap = LONG_HOLD;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            gap--;
         end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            gap = int'($urandom_range(0, 11));
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_beat(input req_type item);
      if (src_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_faces(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_faces.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_surface(input logic [SURF_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we      <= 1'b0;
      surface_cfg = value;
      surface_settings++;
   endtask

   function automatic node_id_type pick_node();
      if ($urandom_range(0, 9) < 8)
         return node_pool[$urandom_range(0, POOL_SIZE - 1)];
      return node_id_type'($urandom);
   endfunction

   function automatic node_id_type pool_or_random(input int p);
      return (p < 0) ? node_id_type'($urandom) : node_pool[p];
   endfunction

   function automatic req_type flag_beat(input int p, input bit value);
      req_type item;
      item.kind        = KIND_FLAG;
      item.element_id  = $urandom;
      item.hex_element = 1'($urandom_range(0, 1));
      item.node_a      = node_pool[p];
      item.node_b      = node_id_type'($urandom);
      item.node_c      = node_id_type'($urandom);
      item.node_d      = node_id_type'($urandom);
      item.node_e      = node_id_type'($urandom);
      item.node_f      = node_id_type'($urandom);
      item.node_g      = node_id_type'($urandom);
      item.node_h      = node_id_type'($urandom);
      item.flag_value  = value;
      return item;
   endfunction

   // pool indices; -1 takes a random node (unused slots of a tetrahedron)
   function automatic req_type element_beat(input logic [ELEM_W-1:0] id, input bit hex,
                                            input int pa, pb, pc, pd,
                                            input int pe = -1, pf = -1, pg = -1, ph = -1);
      req_type item;
      item.kind        = KIND_ELEM;
      item.element_id  = id;
      item.hex_element = hex;
      item.node_a      = pool_or_random(pa);
      item.node_b      = pool_or_random(pb);
      item.node_c      = pool_or_random(pc);
      item.node_d      = pool_or_random(pd);
      item.node_e      = pool_or_random(pe);
      item.node_f      = pool_or_random(pf);
      item.node_g      = pool_or_random(pg);
      item.node_h      = pool_or_random(ph);
      item.flag_value  = 1'($urandom_range(0, 1));
      return item;
   endfunction

   function automatic req_type random_beat(input bit elem_only);
      req_type item;
      item.kind        = (elem_only || $urandom_range(0, 99) >= 35) ? KIND_ELEM : KIND_FLAG;
      item.element_id  = $urandom;
      item.hex_element = 1'($urandom_range(0, 1));
      item.node_a      = pick_node();
      item.node_b      = pick_node();
      item.node_c      = pick_node();
      item.node_d      = pick_node();
      item.node_e      = pick_node();
      item.node_f      = pick_node();
      item.node_g      = pick_node();
      item.node_h      = pick_node();
      item.flag_value  = ($urandom_range(0, 2) != 0);
      return item;
   endfunction

   task automatic test_reset_state();
      send_beat(element_beat($urandom, 1'b1, 0, 1, 2, 3, 4, 5, 6, 7));
      send_beat(element_beat($urandom, 1'b0, 8, 9, 10, 11));
   endtask

   task automatic test_tet_faces();
      send_beat(flag_beat(0, 1'b1));
      send_beat(flag_beat(1, 1'b1));
      send_beat(flag_beat(2, 1'b1));
      send_beat(element_beat($urandom, 1'b0, 0, 1, 2, 3));    // at threshold, one face
      send_beat(flag_beat(3, 1'b1));
      send_beat(element_beat($urandom, 1'b0, 0, 1, 2, 3));    // all four faces
      send_beat(element_beat($urandom, 1'b0, 0, 0, 0, 8));    // repeated node
      send_beat(element_beat($urandom, 1'b0, 0, 8, 9, 1));    // below threshold
   endtask

   task automatic test_hex_faces();
      int k;
      for (k = 4; k < 8; k++)
         send_beat(flag_beat(k, 1'b1));
      send_beat(element_beat($urandom, 1'b1, 0, 1, 2, 3, 4, 5, 6, 7));
      // diagonal corners only: accepted, no full face
      send_beat(element_beat($urandom, 1'b1, 0, 8, 2, 9, 10, 5, 11, 7));
      send_beat(element_beat($urandom, 1'b1, 0, 1, 2, 8, 9, 10, 11, 12));
   endtask

   task automatic test_extreme_ids();
      send_beat(flag_beat(8, 1'b1));
      send_beat(flag_beat(9, 1'b1));
      send_beat(element_beat('0, 1'b0, 8, 9, 8, 9));
      send_beat(element_beat('1, 1'b1, 9, 8, 9, 8, 8, 9, 8, 9));
      send_beat(flag_beat(0, 1'b0));
      send_beat(element_beat($urandom, 1'b1, 0, 1, 2, 3, 4, 5, 6, 7));
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) send_beat(random_beat(1'b0));
   endtask

   task automatic test_output_stall_fill();
      long_hold_req = 1'b1;
      repeat (30) send_beat(random_beat(1'b1));
      wait_drained();
   endtask

   initial begin
      int k;
      logic [15:0] row_base;
      row_base = 16'($urandom);
      for (k = 0; k < 8; k++)
         node_pool[k] = {row_base, 4'(2 * k)};     // shared flag row
      node_pool[8]  = '0;
      node_pool[9]  = '1;
      node_pool[10] = 20'h00001;
      node_pool[11] = 20'hFFFFE;
      for (k = 12; k < POOL_SIZE; k++)
         node_pool[k] = node_id_type'($urandom);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      wait_drained();
      write_surface(16'hFFFF);
      test_tet_faces();
      wait_drained();
      write_surface(16'h0000);
      test_hex_faces();
      wait_drained();
      write_surface(SURF_W'($urandom));
      test_extreme_ids();
      wait_drained();

      write_surface(SURF_W'($urandom));
      test_random_mix(90);
      wait_drained();
      write_surface(16'h8000);
      test_output_stall_fill();
      test_random_mix(60);
      wait_drained();
      write_surface(16'hFFFF);
      src_idling = 1'b0;
      rsp_idling = 1'b0;
      test_random_mix(70);
      wait_drained();

      if (expected_faces.size() != 0)
         report_mismatch("results never delivered", 64'(expected_faces.size()), '0);
      $display("Covered %0d flag writes, %0d elements (%0d hex), %0d faces, %0d status beats,",
               flag_writes, elements, hex_elements, face_beats, status_beats);
      $display("over %0d surface settings, with random stalls and a %0d-cycle output hold.",
               surface_settings, LONG_HOLD);
      if (error_count == 0)
         $display("mesh_contact_face_extractor_tb passed");
      else
         $display("mesh_contact_face_extractor_tb failed");
      $finish;
   end

endmodule
